[sv/beep_dialog_slot_table_defines.svh]
// Assertion helpers for the dialog slot table.
`ifndef BEEP_DIALOG_SLOT_TABLE_DEFINES_SVH
`define BEEP_DIALOG_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BDST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define BDST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/bdst_pkg.sv]
`default_nettype none
package bdst_pkg;
   localparam int KEY_W     = 64;
   localparam int PEER_W    = 16;
   localparam int CRED_W    = 4;
   localparam int TMO_W     = 16;
   localparam int LIMIT_W   = 4;
   localparam int IDX_W     = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 2'd2;

   localparam logic [LIMIT_W-1:0] RETRY_MAX = 4'd15;

   typedef enum logic [1:0] {REQ_BEEP, REQ_OK, REQ_FAIL, REQ_TICK} req_kind_type;
   typedef enum logic [1:0] {MTH_INVITE, MTH_BYE, MTH_CANCEL, MTH_OTHER} method_type;
   typedef enum logic [1:0] {PH_FREE, PH_INVITE, PH_CANCEL, PH_BYE} phase_type;
   typedef enum logic [2:0] {K_INVITE, K_ACK, K_BYE, K_CANCEL, K_STATUS} kind_type;
   typedef enum logic [1:0] {ST_HANDLED, ST_NO_MATCH, ST_FULL, ST_SHORT} status_type;
   typedef enum logic [1:0] {FSM_IDLE, FSM_SCAN, FSM_RESP, FSM_FINAL} fsm_type;

   typedef struct packed {
      logic        accept;
      logic        ptr_clr;
      logic        ptr_inc;
      logic        push;
      kind_type    kind;
      status_type  status;
      logic        last;
      logic        has_slot;
      logic        take;
      logic        set_phase;
      phase_type   phase_val;
      logic        set_deadline;
      logic        dl_retry;
      logic        set_retries;
      logic [LIMIT_W-1:0] retries_val;
      logic        credit_dec;
   } cmd_type;

   typedef struct packed {
      logic              req_valid;
      req_kind_type      req;
      method_type        method;
      logic [CRED_W-1:0] credits;
      phase_type         phase;
      logic              key_hit;
      logic              expired;
      logic [LIMIT_W-1:0] retries;
      logic [LIMIT_W-1:0] limit;
      logic              ptr_last;
      logic              out_free;
   } stat_type;
endpackage
`default_nettype wire

[sv/bdst_req_if.sv]
`default_nettype none
interface bdst_req_if;
   import bdst_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [KEY_W-1:0]   call_key;
   logic [PEER_W-1:0]  peer_ref;
   logic [1:0]         cseq_method;
   logic [CRED_W-1:0]  msg_credits;
   modport source (output valid, req_type, call_key, peer_ref, cseq_method, msg_credits,
                   input ready);
   modport sink (input valid, req_type, call_key, peer_ref, cseq_method, msg_credits,
                 output ready);
endinterface
`default_nettype wire

[sv/bdst_rsp_if.sv]
`default_nettype none
interface bdst_rsp_if;
   import bdst_pkg::*;
   logic              valid;
   logic              ready;
   logic [2:0]        out_kind;
   logic [IDX_W-1:0]  slot_index;
   logic [KEY_W-1:0]  out_key;
   logic [PEER_W-1:0] out_peer;
   logic [1:0]        status;
   logic              last;
   modport source (output valid, out_kind, slot_index, out_key, out_peer, status, last,
                   input ready);
   modport sink (input valid, out_kind, slot_index, out_key, out_peer, status, last,
                 output ready);
endinterface
`default_nettype wire

[sv/bdst_csr_if.sv]
`default_nettype none
interface bdst_csr_if;
   import bdst_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TMO_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/beep_dialog_slot_table.sv]
// A request or response scans one slot per cycle until its slot is found or the table
// ends, then sends its words (1 to 3), one per cycle while the output is free; a tick
// walks all SLOTS slots, pausing for a waiting cancel word, then sends one status word.
// Throughput: one item at a time; next item accepted once the status word is queued.
// Reset: all slots free, time zero, timeout 5, retry delay 1, retry limit 5.
`default_nettype none
module beep_dialog_slot_table #(
   parameter int SLOTS     = 8,
   parameter int TIME_BITS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   bdst_req_if.sink   req_chan,
   bdst_rsp_if.source rsp_chan,
   bdst_csr_if.sink   csr_chan
);
   import bdst_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bdst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   bdst_datapath #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .stat     (stat)
   );
endmodule
`default_nettype wire

[sv/bdst_datapath.sv]
`default_nettype none
module bdst_datapath #(
   parameter int SLOTS     = 8,
   parameter int TIME_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   bdst_req_if.sink          req_chan,
   bdst_rsp_if.source        rsp_chan,
   bdst_csr_if.sink          csr_chan,
   input  bdst_pkg::cmd_type cmd,
   output bdst_pkg::stat_type stat
);
   import bdst_pkg::*;

   localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [TMO_W-1:0]     timeout_ff;
   logic [TMO_W-1:0]     retry_ff;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [TIME_BITS-1:0] time_ff;

   req_kind_type         req_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [PEER_W-1:0]    peer_ff;
   method_type           method_ff;
   logic [CRED_W-1:0]    credits_ff;
   logic [PTR_W-1:0]     ptr_ff;

   phase_type            phase_ff   [SLOTS];
   logic [KEY_W-1:0]     key_tab_ff [SLOTS];
   logic [PEER_W-1:0]    peer_tab_ff[SLOTS];
   logic [TIME_BITS-1:0] dl_tab_ff  [SLOTS];
   logic [LIMIT_W-1:0]   ret_tab_ff [SLOTS];

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_kind_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic [KEY_W-1:0]     rsp_key_ff;
   logic [PEER_W-1:0]    rsp_peer_ff;
   logic [1:0]           rsp_status_ff;
   logic                 rsp_last_ff;

   logic                 accept;
   logic [TIME_BITS-1:0] dl_tmo;
   logic [TIME_BITS-1:0] dl_retry;
   logic [TIME_BITS-1:0] age;

   assign accept   = req_chan.valid && cmd.accept;
   assign req_chan.ready = cmd.accept;
   assign csr_chan.ready = 1'b1;
   assign dl_tmo   = time_ff + TIME_BITS'(timeout_ff);
   assign dl_retry = time_ff + TIME_BITS'(retry_ff);
   // deadline passed when the wrapped age has its top bit clear
   assign age      = time_ff - dl_tab_ff[ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TMO_W'(5);
         retry_ff   <= TMO_W'(1);
         limit_ff   <= LIMIT_W'(5);
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_TIMEOUT: timeout_ff <= csr_chan.data;
            CSR_RETRY:   retry_ff   <= csr_chan.data;
            CSR_LIMIT:   limit_ff   <= csr_chan.data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (accept && req_kind_type'(req_chan.req_type) == REQ_TICK) begin
         time_ff <= time_ff + TIME_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff    <= req_kind_type'(req_chan.req_type);
         key_ff    <= req_chan.call_key;
         peer_ff   <= req_chan.peer_ref;
         method_ff <= method_type'(req_chan.cseq_method);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         credits_ff <= req_chan.msg_credits;
      end else if (cmd.credit_dec) begin
         credits_ff <= credits_ff - CRED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.ptr_clr) begin
         ptr_ff <= '0;
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            phase_ff[i]   <= PH_FREE;
            ret_tab_ff[i] <= '0;
         end
      end else if (cmd.take) begin
         phase_ff[ptr_ff]   <= PH_INVITE;
         ret_tab_ff[ptr_ff] <= '0;
      end else begin
         if (cmd.set_phase) begin
            phase_ff[ptr_ff] <= cmd.phase_val;
         end
         if (cmd.set_retries) begin
            ret_tab_ff[ptr_ff] <= cmd.retries_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         key_tab_ff[ptr_ff]  <= key_ff;
         peer_tab_ff[ptr_ff] <= peer_ff;
         dl_tab_ff[ptr_ff]   <= dl_tmo;
      end else if (cmd.set_deadline) begin
         dl_tab_ff[ptr_ff]   <= cmd.dl_retry ? dl_retry : dl_tmo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_kind_ff   <= cmd.kind;
         rsp_status_ff <= cmd.status;
         rsp_last_ff   <= cmd.last;
         rsp_idx_ff    <= cmd.has_slot ? IDX_W'(ptr_ff) : '0;
         rsp_key_ff    <= cmd.has_slot ? key_tab_ff[ptr_ff] : '0;
         rsp_peer_ff   <= cmd.has_slot ? peer_tab_ff[ptr_ff] : '0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_kind   = rsp_kind_ff;
   assign rsp_chan.slot_index = rsp_idx_ff;
   assign rsp_chan.out_key    = rsp_key_ff;
   assign rsp_chan.out_peer   = rsp_peer_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.last       = rsp_last_ff;

   always_comb begin
      stat.req_valid = req_chan.valid;
      stat.req       = req_ff;
      stat.method    = method_ff;
      stat.credits   = credits_ff;
      stat.phase     = phase_ff[ptr_ff];
      stat.key_hit   = key_tab_ff[ptr_ff] == key_ff;
      stat.expired   = !age[TIME_BITS-1];
      stat.retries   = ret_tab_ff[ptr_ff];
      stat.limit     = limit_ff;
      stat.ptr_last  = ptr_ff == PTR_W'(SLOTS - 1);
      stat.out_free  = !rsp_valid_ff || rsp_chan.ready;
   end
endmodule
`default_nettype wire

[sv/bdst_ctrl.sv]
`default_nettype none
`include "beep_dialog_slot_table_defines.svh"
module bdst_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  bdst_pkg::stat_type stat,
   output bdst_pkg::cmd_type  cmd
);
   import bdst_pkg::*;

   fsm_type     state_ff, state_in;
   logic [1:0]  step_ff, step_in;
   status_type  code_ff, code_in;
   logic        short_ff, short_in;

   logic               advance;
   logic               done;
   logic               short_now;
   logic               is_inv;
   status_type         code_now;
   logic [LIMIT_W-1:0] ret_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         step_ff  <= '0;
         code_ff  <= ST_HANDLED;
         short_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         code_ff  <= code_in;
         short_ff <= short_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      code_in   = code_ff;
      short_in  = short_ff;
      cmd       = '0;
      advance   = 1'b1;
      done      = 1'b0;
      short_now = 1'b0;
      code_now  = ST_HANDLED;
      ret_next  = (stat.retries == RETRY_MAX) ? RETRY_MAX : stat.retries + LIMIT_W'(1);
      is_inv    = stat.method == MTH_INVITE &&
                  (stat.phase == PH_INVITE || stat.phase == PH_CANCEL);

      unique case (state_ff)
         FSM_IDLE: begin
            cmd.accept = 1'b1;
            if (stat.req_valid) begin
               state_in    = FSM_SCAN;
               step_in     = '0;
               short_in    = 1'b0;
               cmd.ptr_clr = 1'b1;
            end
         end
         FSM_SCAN: begin
            unique case (stat.req) inside
               REQ_BEEP: begin
                  code_now = ST_FULL;
                  if (stat.phase == PH_FREE) begin
                     cmd.take = 1'b1;
                     advance  = 1'b0;
                     state_in = FSM_RESP;
                  end
               end
               REQ_OK, REQ_FAIL: begin
                  code_now = ST_NO_MATCH;
                  if (stat.phase != PH_FREE && stat.key_hit) begin
                     advance  = 1'b0;
                     state_in = FSM_RESP;
                  end
               end
               default: begin
                  if (stat.phase != PH_FREE && stat.expired) begin
                     if (stat.phase != PH_INVITE) begin
                        cmd.set_phase = 1'b1;
                        cmd.phase_val = PH_FREE;
                     end else if (stat.credits != '0) begin
                        if (stat.out_free) begin
                           cmd.push         = 1'b1;
                           cmd.kind         = K_CANCEL;
                           cmd.status       = ST_HANDLED;
                           cmd.has_slot     = 1'b1;
                           cmd.set_phase    = 1'b1;
                           cmd.phase_val    = PH_CANCEL;
                           cmd.set_deadline = 1'b1;
                           cmd.credit_dec   = 1'b1;
                        end else begin
                           advance = 1'b0;
                        end
                     end else begin
                        short_now       = 1'b1;
                        cmd.set_retries = 1'b1;
                        cmd.retries_val = ret_next;
                        if (ret_next < stat.limit) begin
                           cmd.set_deadline = 1'b1;
                           cmd.dl_retry     = 1'b1;
                        end else begin
                           cmd.set_phase = 1'b1;
                           cmd.phase_val = PH_FREE;
                        end
                     end
                  end
                  short_in = short_ff || short_now;
                  code_now = (short_ff || short_now) ? ST_SHORT : ST_HANDLED;
               end
            endcase
            if (advance) begin
               if (stat.ptr_last) begin
                  state_in = FSM_FINAL;
                  code_in  = code_now;
               end else begin
                  cmd.ptr_inc = 1'b1;
               end
            end
         end
         FSM_RESP: begin
            if (stat.out_free) begin
               cmd.push     = 1'b1;
               cmd.has_slot = 1'b1;
               cmd.kind     = K_STATUS;
               cmd.status   = ST_HANDLED;
               cmd.last     = 1'b1;
               done         = 1'b1;
               if (stat.req == REQ_BEEP) begin
                  if (stat.credits == '0) begin
                     cmd.status = ST_SHORT;
                  end else if (step_ff == 2'd0) begin
                     cmd.kind = K_INVITE;
                     cmd.last = 1'b0;
                     done     = 1'b0;
                  end
               end else if (is_inv && stat.req == REQ_OK) begin
                  // ack, then bye; phase moves to bye only once both went out
                  if (stat.credits == '0) begin
                     cmd.status = ST_SHORT;
                  end else if (step_ff == 2'd0) begin
                     cmd.kind       = K_ACK;
                     cmd.last       = 1'b0;
                     done           = 1'b0;
                     cmd.credit_dec = 1'b1;
                  end else if (step_ff == 2'd1) begin
                     cmd.kind = K_BYE;
                     cmd.last = 1'b0;
                     done     = 1'b0;
                  end else begin
                     cmd.set_phase    = 1'b1;
                     cmd.phase_val    = PH_BYE;
                     cmd.set_deadline = 1'b1;
                  end
               end else if (is_inv) begin
                  if (stat.credits == '0) begin
                     cmd.status = ST_SHORT;
                  end else if (step_ff == 2'd0) begin
                     cmd.kind = K_ACK;
                     cmd.last = 1'b0;
                     done     = 1'b0;
                  end else begin
                     cmd.set_phase = 1'b1;
                     cmd.phase_val = PH_FREE;
                  end
               end else if (stat.req == REQ_FAIL || stat.method == MTH_BYE) begin
                  cmd.set_phase = 1'b1;
                  cmd.phase_val = PH_FREE;
               end
               if (done) begin
                  state_in = FSM_IDLE;
               end else begin
                  step_in = step_ff + 2'd1;
               end
            end
         end
         FSM_FINAL: begin
            if (stat.out_free) begin
               cmd.push   = 1'b1;
               cmd.kind   = K_STATUS;
               cmd.status = code_ff;
               cmd.last   = 1'b1;
               state_in   = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   `BDST_ASSERT_NOW(a_push_room, cmd.push, stat.out_free, "word pushed over a pending word")
   `BDST_ASSERT_NOW(a_credit_avail, cmd.credit_dec, stat.credits != '0, "credit underflow")
   `BDST_ASSERT_NEXT(a_last_ends, cmd.push && cmd.last, state_ff == FSM_IDLE,
                     "final word did not end the item")
   `BDST_ASSERT_NOW(a_take_free, cmd.take, stat.phase == PH_FREE && state_ff == FSM_SCAN,
                    "busy slot taken")
endmodule
`default_nettype wire

[sim/tb_beep_dialog_slot_table.sv]
`default_nettype none
module tb_beep_dialog_slot_table;
   import bdst_pkg::*;

   localparam int N_SLOTS    = 8;
   localparam int DRAIN_CYC  = 24;
   localparam int HOLD_CYC   = 300;
   localparam int IDLE_LIMIT = 6000;

   typedef struct packed {
      req_kind_type      rtype;
      logic [KEY_W-1:0]  key;
      logic [PEER_W-1:0] peer;
      method_type        mth;
      logic [CRED_W-1:0] cred;
   } call_evt_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [IDX_W-1:0]  idx;
      logic [KEY_W-1:0]  key;
      logic [PEER_W-1:0] peer;
      logic [1:0]        status;
      logic              last;
   } dialog_msg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdst_req_if req_if ();
   bdst_rsp_if rsp_if ();
   bdst_csr_if csr_if ();

   beep_dialog_slot_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   // shadow of the slot table
   phase_type         sh_phase [N_SLOTS];
   logic [KEY_W-1:0]  sh_key   [N_SLOTS];
   logic [PEER_W-1:0] sh_peer  [N_SLOTS];
   logic [31:0]       sh_dl    [N_SLOTS];
   logic [3:0]        sh_rtr   [N_SLOTS];
   logic [31:0]       sh_now;
   logic [15:0]       cfg_tmo;
   logic [15:0]       cfg_rdly;
   logic [3:0]        cfg_lim;

   dialog_msg_type msg_q [$];
   int errors      = 0;
   int n_sent      = 0;
   int n_words     = 0;
   int n_cfg       = 0;
   bit tx_nogap    = 0;
   bit rx_nogap    = 0;
   int hold_req    = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int rx_wait     = 0;
   int idle_cnt    = 0;
   logic [KEY_W-1:0] key_pool [8];

   task automatic clear_slot(int s);
      sh_phase[s] = PH_FREE;
      sh_key[s]   = '0;
      sh_peer[s]  = '0;
      sh_dl[s]    = '0;
      sh_rtr[s]   = '0;
   endtask

   task automatic queue_msg(kind_type k, int s, bit has, status_type st, bit l);
      dialog_msg_type m;
      m.kind   = k;
      m.idx    = has ? s[IDX_W-1:0] : '0;
      m.key    = has ? sh_key[s] : '0;
      m.peer   = has ? sh_peer[s] : '0;
      m.status = st;
      m.last   = l;
      msg_q.push_back(m);
   endtask

   function automatic bit deadline_hit(logic [31:0] dl);
      logic [31:0] d;
      d = sh_now - dl;
      return d[31] == 1'b0;
   endfunction

   task automatic predict_dialog(call_evt_type ev);
      int s;
      int hit;
      int cr;
      bit short_buf;
      cr  = ev.cred;
      hit = -1;
      case (ev.rtype)
         REQ_BEEP: begin
            for (s = 0; s < N_SLOTS; s++)
               if (hit < 0 && sh_phase[s] == PH_FREE) hit = s;
            if (hit < 0) begin
               queue_msg(K_STATUS, 0, 0, ST_FULL, 1);
            end else begin
               sh_phase[hit] = PH_INVITE;
               sh_key[hit]   = ev.key;
               sh_peer[hit]  = ev.peer;
               sh_rtr[hit]   = '0;
               sh_dl[hit]    = sh_now + cfg_tmo;
               if (cr == 0) begin
                  queue_msg(K_STATUS, hit, 1, ST_SHORT, 1);
               end else begin
                  queue_msg(K_INVITE, hit, 1, ST_HANDLED, 0);
                  queue_msg(K_STATUS, hit, 1, ST_HANDLED, 1);
               end
            end
         end
         REQ_OK, REQ_FAIL: begin
            for (s = 0; s < N_SLOTS; s++)
               if (hit < 0 && sh_phase[s] != PH_FREE && sh_key[s] == ev.key) hit = s;
            if (hit < 0) begin
               queue_msg(K_STATUS, 0, 0, ST_NO_MATCH, 1);
            end else if (ev.mth == MTH_INVITE &&
                         (sh_phase[hit] == PH_INVITE || sh_phase[hit] == PH_CANCEL)) begin
               if (ev.rtype == REQ_OK) begin
                  if (cr > 0) begin
                     cr--;
                     queue_msg(K_ACK, hit, 1, ST_HANDLED, 0);
                  end
                  if (cr == 0) begin
                     queue_msg(K_STATUS, hit, 1, ST_SHORT, 1);
                  end else begin
                     queue_msg(K_BYE, hit, 1, ST_HANDLED, 0);
                     sh_phase[hit] = PH_BYE;
                     sh_dl[hit]    = sh_now + cfg_tmo;
                     queue_msg(K_STATUS, hit, 1, ST_HANDLED, 1);
                  end
               end else if (cr == 0) begin
                  queue_msg(K_STATUS, hit, 1, ST_SHORT, 1);
               end else begin
                  queue_msg(K_ACK, hit, 1, ST_HANDLED, 0);
                  queue_msg(K_STATUS, hit, 1, ST_HANDLED, 1);
                  clear_slot(hit);
               end
            end else begin
               queue_msg(K_STATUS, hit, 1, ST_HANDLED, 1);
               if (ev.rtype == REQ_FAIL || ev.mth == MTH_BYE) clear_slot(hit);
            end
         end
         default: begin
            short_buf = 0;
            sh_now    = sh_now + 1;
            for (s = 0; s < N_SLOTS; s++) begin
               if (sh_phase[s] != PH_FREE && deadline_hit(sh_dl[s])) begin
                  if (sh_phase[s] != PH_INVITE) begin
                     clear_slot(s);
                  end else if (cr > 0) begin
                     cr--;
                     queue_msg(K_CANCEL, s, 1, ST_HANDLED, 0);
                     sh_phase[s] = PH_CANCEL;
                     sh_dl[s]    = sh_now + cfg_tmo;
                  end else begin
                     short_buf = 1;
                     if (sh_rtr[s] < RETRY_MAX) sh_rtr[s]++;
                     if (sh_rtr[s] < cfg_lim) sh_dl[s] = sh_now + cfg_rdly;
                     else clear_slot(s);
                  end
               end
            end
            queue_msg(K_STATUS, 0, 0, short_buf ? ST_SHORT : ST_HANDLED, 1);
         end
      endcase
   endtask

   // call only right after a rising edge
   task automatic send_evt(call_evt_type ev);
      int gap;
      gap = tx_nogap ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= ev.rtype;
      req_if.call_key    <= ev.key;
      req_if.peer_ref    <= ev.peer;
      req_if.cseq_method <= ev.mth;
      req_if.msg_credits <= ev.cred;
      do @(posedge clock); while (!req_if.ready);
      predict_dialog(ev);
      n_sent++;
   endtask

   task automatic send(req_kind_type t, logic [63:0] k, logic [15:0] p,
                       method_type m, logic [3:0] c);
      call_evt_type ev;
      ev = '{rtype: t, key: k, peer: p, mth: m, cred: c};
      send_evt(ev);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (msg_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_TIMEOUT: cfg_tmo  = val;
         CSR_RETRY:   cfg_rdly = val;
         default:     cfg_lim  = val[3:0];
      endcase
      n_cfg++;
      @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] tmo, logic [15:0] rdly, logic [3:0] lim);
      settle();
      write_reg(CSR_TIMEOUT, tmo);
      write_reg(CSR_RETRY, rdly);
      write_reg(CSR_LIMIT, lim);
   endtask

   function automatic logic [63:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      int i;
      logic [63:0] k;
      // extreme fields, beep without buffer still takes a slot
      send(REQ_BEEP, '1, 16'hFFFF, MTH_OTHER, 4'hF);
      send(REQ_BEEP, '0, 16'h0000, MTH_INVITE, 4'h0);
      send(REQ_OK, '1, 16'h0, MTH_INVITE, 4'h1);      // ack only, buffer short
      send(REQ_OK, '1, 16'h0, MTH_INVITE, 4'h0);      // nothing sent
      send(REQ_OK, '1, 16'h0, MTH_INVITE, 4'h2);      // ack and bye
      send(REQ_OK, '1, 16'h0, MTH_OTHER, 4'h3);       // absorbed
      send(REQ_OK, '1, 16'h0, MTH_BYE, 4'h3);         // bye answer frees
      send(REQ_FAIL, '0, 16'h0, MTH_INVITE, 4'h0);    // failure w/o buffer
      send(REQ_FAIL, '0, 16'h0, MTH_INVITE, 4'h1);    // ack then free
      send(REQ_FAIL, 64'h1234, 16'h0, MTH_INVITE, 4'h1); // no match
      k = rand_key();
      // duplicate keys, then fill the table
      for (i = 0; i < N_SLOTS + 1; i++)
         send(REQ_BEEP, (i < 2) ? k : rand_key(), 16'($urandom), MTH_INVITE, 4'h1);
      send(REQ_FAIL, k, 16'h0, MTH_CANCEL, 4'h0);     // other failure frees lowest
      // expire: cancels with few buffers, short status
      for (i = 0; i < 6; i++)
         send(REQ_TICK, rand_key(), 16'($urandom), MTH_OTHER, 4'h2);
   endtask

   task automatic random_evt(int wide_p);
      call_evt_type ev;
      int r;
      r       = $urandom_range(0, 99);
      ev.key  = key_pool[$urandom_range(0, 7)];
      ev.peer = 16'($urandom);
      ev.mth  = ($urandom_range(0, 3) != 0) ? MTH_INVITE : method_type'($urandom_range(0, 3));
      ev.cred = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3))
                                            : 4'($urandom_range(0, 15));
      if (r < 28) ev.rtype = REQ_BEEP;
      else if (r < 50) ev.rtype = REQ_OK;
      else if (r < 64) ev.rtype = REQ_FAIL;
      else ev.rtype = REQ_TICK;
      if ($urandom_range(0, 99) < wide_p) ev.key = rand_key();
      if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, 7)] = rand_key();
      send_evt(ev);
   endtask

   task automatic test_random(int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            tx_nogap = ($urandom_range(0, 3) == 0);
            rx_nogap = ($urandom_range(0, 3) == 0);
         end
         random_evt(6);
      end
      tx_nogap = 0;
      rx_nogap = 0;
   endtask

   task automatic test_backpressure();
      int i;
      hold_req++;
      tx_nogap = 1;
      for (i = 0; i < 30; i++) random_evt(6);
      tx_nogap = 0;
   endtask

   // result side: random stalls, long hold-off on request, checking
   always @(posedge clock) begin
      dialog_msg_type got;
      dialog_msg_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{kind: rsp_if.out_kind, idx: rsp_if.slot_index, key: rsp_if.out_key,
                    peer: rsp_if.out_peer, status: rsp_if.status, last: rsp_if.last};
            n_words++;
            if (msg_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected word kind=%0d idx=%0d key=%h peer=%h st=%0d last=%0d",
                        $time, got.kind, got.idx, got.key, got.peer, got.status, got.last);
            end else begin
               want = msg_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch exp kind=%0d idx=%0d key=%h peer=%h st=%0d last=%0d",
                           $time, want.kind, want.idx, want.key, want.peer, want.status,
                           want.last);
                  $display("%0t:          act kind=%0d idx=%0d key=%h peer=%h st=%0d last=%0d",
                           $time, got.kind, got.idx, got.key, got.peer, got.status, got.last);
               end
            end
            rx_wait = rx_nogap ? 0 : $urandom_range(0, 13);
         end
         if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYC;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready) || reset)
         idle_cnt = 0;
      else
         idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
         $display("%0t: watchdog, %0d words still expected", $time, msg_q.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int i;
      req_if.valid       = 1'b0;
      req_if.req_type    = '0;
      req_if.call_key    = '0;
      req_if.peer_ref    = '0;
      req_if.cseq_method = '0;
      req_if.msg_credits = '0;
      csr_if.valid       = 1'b0;
      csr_if.index       = '0;
      csr_if.data        = '0;
      sh_now   = '0;
      cfg_tmo  = 16'd5;
      cfg_rdly = 16'd1;
      cfg_lim  = 4'd5;
      for (i = 0; i < N_SLOTS; i++) begin
         clear_slot(i);
         key_pool[i] = rand_key();
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      set_config(16'd1, 16'd1, 4'd1);
      test_random(60);
      set_config(16'd3, 16'd2, 4'd15);
      test_random(80);
      test_backpressure();
      set_config(16'd65535, 16'd65535, 4'd15);
      test_random(50);
      set_config(16'd2, 16'd65535, 4'd3);
      test_random(70);
      set_config(16'd6, 16'd1, 4'd1);
      test_random(70);
      set_config(16'd4, 16'd3, 4'd8);
      test_random(40);
      settle();

      $display("Covered %0d call events, %0d result words, %0d register writes,",
               n_sent, n_words, n_cfg);
      $display("with timeouts and retry limits at both ends and a long result stall.");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/bdst_pkg.sv
sv/bdst_req_if.sv
sv/bdst_rsp_if.sv
sv/bdst_csr_if.sv
sv/bdst_datapath.sv
sv/bdst_ctrl.sv
sv/beep_dialog_slot_table.sv
sim/tb_beep_dialog_slot_table.sv
